@@ rtl/accel_motion_hysteresis_detector_defines.svh @@
// Assertion macros for the verification code of the motion detector.
`ifndef ACCEL_MOTION_HYSTERESIS_DETECTOR_DEFINES_SVH
`define ACCEL_MOTION_HYSTERESIS_DETECTOR_DEFINES_SVH

// Same-cycle implication.
`define AMHD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define AMHD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/amhd_pkg.sv @@
`timescale 1ns / 1ps
package amhd_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int THR_W       = 32;
   localparam int HOLD_W      = 16;
   localparam int NOW_W       = 32;
   localparam int SQ_W        = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_HIGH_THRESHOLD_SQ = csr_index_type'(0);
   localparam csr_index_type CSR_LOW_THRESHOLD_SQ  = csr_index_type'(1);
   localparam csr_index_type CSR_ABOVE_HOLD_MS     = csr_index_type'(2);
   localparam csr_index_type CSR_BELOW_HOLD_MS     = csr_index_type'(3);

   localparam logic [THR_W-1:0]  HIGH_THRESHOLD_SQ_RST = THR_W'(167772);
   localparam logic [THR_W-1:0]  LOW_THRESHOLD_SQ_RST  = THR_W'(41943);
   localparam logic [HOLD_W-1:0] ABOVE_HOLD_MS_RST     = HOLD_W'(1000);
   localparam logic [HOLD_W-1:0] BELOW_HOLD_MS_RST     = HOLD_W'(3000);

   typedef struct packed {
      logic                       kind;
      logic signed [SAMPLE_W-1:0] accel_x;
      logic signed [SAMPLE_W-1:0] accel_y;
      logic signed [SAMPLE_W-1:0] accel_z;
      logic [NOW_W-1:0]           now_ms;
   } req_payload_type;

   typedef struct packed {
      logic                       moving;
      logic                       have_sample;
      logic signed [SAMPLE_W-1:0] held_x;
      logic signed [SAMPLE_W-1:0] held_y;
      logic signed [SAMPLE_W-1:0] held_z;
   } rsp_payload_type;

   typedef struct packed {
      logic [THR_W-1:0]  high_threshold_sq;
      logic [THR_W-1:0]  low_threshold_sq;
      logic [HOLD_W-1:0] above_hold_ms;
      logic [HOLD_W-1:0] below_hold_ms;
   } cfg_type;

   // Poll after the squaring stage.
   typedef struct packed {
      logic                       kind;
      logic [NOW_W-1:0]           now_ms;
      logic signed [SAMPLE_W-1:0] sample_x;
      logic signed [SAMPLE_W-1:0] sample_y;
      logic signed [SAMPLE_W-1:0] sample_z;
      logic [SQ_W-1:0]            sq_x;
      logic [SQ_W-1:0]            sq_y;
      logic [SQ_W-1:0]            sq_z;
   } sq_stage_type;

   // Magnitude fits 16 bits unsigned even for the most negative code.
   function automatic logic [SQ_W-1:0] square_abs(input logic signed [SAMPLE_W-1:0] v);
      logic [SAMPLE_W-1:0] mag;
      mag = v[SAMPLE_W-1] ? SAMPLE_W'(-v) : SAMPLE_W'(v);
      return SQ_W'(mag) * SQ_W'(mag);
   endfunction

endpackage

@@ rtl/accel_motion_hysteresis_detector.sv @@
`timescale 1ns / 1ps
// Path: after its request transfer a poll goes through the squaring register, then
//   the decision logic into the result register.
// Throughput: one poll per cycle; the result register path bounds it, so a stalled
//   result holds the pipeline only once both stages are full.
// Reset: clears the held sample, both timers, the motion flag and all valid bits,
//   and loads the threshold and hold registers with their defaults.
module accel_motion_hysteresis_detector #(
   parameter int TIME_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  amhd_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output amhd_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  amhd_pkg::csr_index_type   csr_index,
   input  logic [31:0]               csr_wdata
);
   import amhd_pkg::*;

   cfg_type      cfg;
   logic         s1_valid;
   logic         s1_ready;
   sq_stage_type s1_data;

   amhd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   amhd_square u_square (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .s1_valid    (s1_valid),
      .s1_ready    (s1_ready),
      .s1_data     (s1_data)
   );

   amhd_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .s1_valid    (s1_valid),
      .s1_ready    (s1_ready),
      .s1_data     (s1_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ rtl/amhd_csr.sv @@
`timescale 1ns / 1ps
module amhd_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  amhd_pkg::csr_index_type csr_index,
   input  logic [31:0]             csr_wdata,
   output amhd_pkg::cfg_type       cfg
);
   import amhd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HIGH_THRESHOLD_SQ: cfg_in.high_threshold_sq = csr_wdata[THR_W-1:0];
            CSR_LOW_THRESHOLD_SQ:  cfg_in.low_threshold_sq  = csr_wdata[THR_W-1:0];
            CSR_ABOVE_HOLD_MS:     cfg_in.above_hold_ms     = csr_wdata[HOLD_W-1:0];
            CSR_BELOW_HOLD_MS:     cfg_in.below_hold_ms     = csr_wdata[HOLD_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.high_threshold_sq <= HIGH_THRESHOLD_SQ_RST;
         cfg_ff.low_threshold_sq  <= LOW_THRESHOLD_SQ_RST;
         cfg_ff.above_hold_ms     <= ABOVE_HOLD_MS_RST;
         cfg_ff.below_hold_ms     <= BELOW_HOLD_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/amhd_square.sv @@
`timescale 1ns / 1ps
module amhd_square (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  amhd_pkg::req_payload_type req_payload,
   output logic                      s1_valid,
   input  logic                      s1_ready,
   output amhd_pkg::sq_stage_type    s1_data
);
   import amhd_pkg::*;

   logic         s1_valid_ff;
   logic         s1_valid_in;
   sq_stage_type s1_data_ff;
   sq_stage_type s1_data_in;

   assign req_ready = !s1_valid_ff || s1_ready;
   assign s1_valid  = s1_valid_ff;
   assign s1_data   = s1_data_ff;

   always_comb begin
      s1_valid_in = req_ready ? req_valid : s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_valid && req_ready) begin
         s1_data_in.kind     = req_payload.kind;
         s1_data_in.now_ms   = req_payload.now_ms;
         s1_data_in.sample_x = req_payload.accel_x;
         s1_data_in.sample_y = req_payload.accel_y;
         s1_data_in.sample_z = req_payload.accel_z;
         s1_data_in.sq_x     = square_abs(req_payload.accel_x);
         s1_data_in.sq_y     = square_abs(req_payload.accel_y);
         s1_data_in.sq_z     = square_abs(req_payload.accel_z);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
   end

endmodule

@@ rtl/amhd_core.sv @@
`timescale 1ns / 1ps
module amhd_core #(
   parameter int TIME_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  amhd_pkg::cfg_type         cfg,
   input  logic                      s1_valid,
   output logic                      s1_ready,
   input  amhd_pkg::sq_stage_type    s1_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output amhd_pkg::rsp_payload_type rsp_payload
);
   import amhd_pkg::*;

   logic signed [SAMPLE_W-1:0] held_x_ff, held_x_in;
   logic signed [SAMPLE_W-1:0] held_y_ff, held_y_in;
   logic signed [SAMPLE_W-1:0] held_z_ff, held_z_in;
   logic                       seen_ff, seen_in;
   logic [SQ_W-1:0]            msq_ff, msq_in;
   logic [TIME_BITS-1:0]       above_start_ff, above_start_in;
   logic                       above_armed_ff, above_armed_in;
   logic [TIME_BITS-1:0]       below_start_ff, below_start_in;
   logic                       below_armed_ff, below_armed_in;
   logic                       motion_ff, motion_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_payload_type            rsp_payload_ff, rsp_payload_in;

   logic                 take;
   logic [TIME_BITS-1:0] now_t;
   logic [SQ_W-1:0]      msq_sum;

   assign s1_ready    = !rsp_valid_ff || rsp_ready;
   assign take        = s1_valid && s1_ready;
   assign now_t       = TIME_BITS'(s1_data.now_ms);
   assign msq_sum     = s1_data.sq_x + s1_data.sq_y + s1_data.sq_z;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      held_x_in      = held_x_ff;
      held_y_in      = held_y_ff;
      held_z_in      = held_z_ff;
      seen_in        = seen_ff;
      msq_in         = msq_ff;
      above_start_in = above_start_ff;
      above_armed_in = above_armed_ff;
      below_start_in = below_start_ff;
      below_armed_in = below_armed_ff;
      motion_in      = motion_ff;
      rsp_valid_in   = s1_ready ? s1_valid : rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;

      if (take) begin
         if (s1_data.kind) begin
            held_x_in = s1_data.sample_x;
            held_y_in = s1_data.sample_y;
            held_z_in = s1_data.sample_z;
            seen_in   = 1'b1;
            msq_in    = msq_sum;
         end

         if (seen_in) begin
            // High test wins when the thresholds cross.
            priority if (msq_in > cfg.high_threshold_sq) begin
               if (!above_armed_ff) begin
                  above_start_in = now_t;
                  above_armed_in = 1'b1;
               end
               below_armed_in = 1'b0;
            end else if (msq_in < cfg.low_threshold_sq) begin
               if (!below_armed_ff) begin
                  below_start_in = now_t;
                  below_armed_in = 1'b1;
               end
               above_armed_in = 1'b0;
            end else begin
               above_armed_in = above_armed_ff;
            end

            // Elapsed time wraps modulo the timer width; clearing wins.
            if (above_armed_in &&
                (now_t - above_start_in) >= TIME_BITS'(cfg.above_hold_ms)) begin
               motion_in = 1'b1;
            end
            if (below_armed_in &&
                (now_t - below_start_in) >= TIME_BITS'(cfg.below_hold_ms)) begin
               motion_in = 1'b0;
            end
         end

         rsp_payload_in.moving      = motion_in;
         rsp_payload_in.have_sample = seen_in;
         rsp_payload_in.held_x      = held_x_in;
         rsp_payload_in.held_y      = held_y_in;
         rsp_payload_in.held_z      = held_z_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_x_ff      <= '0;
         held_y_ff      <= '0;
         held_z_ff      <= '0;
         seen_ff        <= 1'b0;
         msq_ff         <= '0;
         above_start_ff <= '0;
         above_armed_ff <= 1'b0;
         below_start_ff <= '0;
         below_armed_ff <= 1'b0;
         motion_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         held_x_ff      <= held_x_in;
         held_y_ff      <= held_y_in;
         held_z_ff      <= held_z_in;
         seen_ff        <= seen_in;
         msq_ff         <= msq_in;
         above_start_ff <= above_start_in;
         above_armed_ff <= above_armed_in;
         below_start_ff <= below_start_in;
         below_armed_ff <= below_armed_in;
         motion_ff      <= motion_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

@@ rtl/amhd_checker.sv @@
`timescale 1ns / 1ps
`include "accel_motion_hysteresis_detector_defines.svh"
module amhd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input amhd_pkg::rsp_payload_type rsp_payload
);
   import amhd_pkg::*;

   logic rsp_stall;
   logic rsp_done;
   logic held_zero;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_done  = rsp_valid && rsp_ready;
   assign held_zero = rsp_payload.held_x == 16'sd0 && rsp_payload.held_y == 16'sd0 &&
                      rsp_payload.held_z == 16'sd0;

   // A stalled result holds.
   `AMHD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
                     rsp_valid && $stable(rsp_payload), "rsp changed while stalled")

   // Pipeline comes out of reset empty.
   `AMHD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid,
                     "rsp valid right after reset")

   // Before any sample the held values are zero and no motion is declared.
   `AMHD_ASSERT_NOW(a_no_sample, clock, reset, rsp_valid && !rsp_payload.have_sample,
                    !rsp_payload.moving && held_zero, "state without sample")

   // Once a sample is held it stays held for the following result.
   `AMHD_ASSERT_NEXT(a_sample_sticky, clock, reset, rsp_done && rsp_payload.have_sample,
                     !rsp_valid || rsp_payload.have_sample, "have_sample dropped")

endmodule

bind accel_motion_hysteresis_detector amhd_checker u_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
   import amhd_pkg::*;

   localparam logic KIND_POLL   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;
   localparam int   PHASES      = 10;
   localparam int   RUN_LEN     = 63;
   localparam int   MAX_REPORTS = 10;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   csr_index_type   csr_index = CSR_HIGH_THRESHOLD_SQ;
   logic [31:0]     csr_wdata = '0;

   accel_motion_hysteresis_detector DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   // Register copies seen by the motion predictor
   logic [THR_W-1:0]  cfg_high_sq    = HIGH_THRESHOLD_SQ_RST;
   logic [THR_W-1:0]  cfg_low_sq     = LOW_THRESHOLD_SQ_RST;
   logic [HOLD_W-1:0] cfg_rise_hold  = ABOVE_HOLD_MS_RST;
   logic [HOLD_W-1:0] cfg_fall_hold  = BELOW_HOLD_MS_RST;

   // Detector state as predicted
   logic signed [SAMPLE_W-1:0] last_x = '0;
   logic signed [SAMPLE_W-1:0] last_y = '0;
   logic signed [SAMPLE_W-1:0] last_z = '0;
   logic                       got_sample   = 1'b0;
   logic [NOW_W-1:0]           rise_since   = '0;
   logic                       rise_running = 1'b0;
   logic [NOW_W-1:0]           fall_since   = '0;
   logic                       fall_running = 1'b0;
   logic                       moving_now   = 1'b0;

   req_payload_type poll_q[$];
   rsp_payload_type expected_status_q[$];
   int              mismatch_count = 0;
   int              send_idle_pct  = 0;
   int              recv_idle_pct  = 0;
   logic            req_done       = 1'b0;

   // Stimulus generator state
   logic [NOW_W-1:0] clock_ms  = '0;
   int unsigned      step_max  = 1;
   int               amp_bits  = 8;

   function automatic longint unsigned axis_energy(logic signed [SAMPLE_W-1:0] v);
      longint s;
      s = v;
      if (s < 0)
         s = -s;
      return longint'(s * s);
   endfunction

   function automatic rsp_payload_type motion_after_poll(req_payload_type p);
      longint unsigned energy;
      logic [NOW_W-1:0] elapsed;
      rsp_payload_type  r;
      if (p.kind == KIND_SAMPLE) begin
         last_x     = p.accel_x;
         last_y     = p.accel_y;
         last_z     = p.accel_z;
         got_sample = 1'b1;
      end
      if (got_sample) begin
         energy = axis_energy(last_x) + axis_energy(last_y) + axis_energy(last_z);
         // high test first: it wins when the thresholds are crossed
         if (energy > longint'(cfg_high_sq)) begin
            if (!rise_running) begin
               rise_since   = p.now_ms;
               rise_running = 1'b1;
            end
            fall_running = 1'b0;
         end else if (energy < longint'(cfg_low_sq)) begin
            if (!fall_running) begin
               fall_since   = p.now_ms;
               fall_running = 1'b1;
            end
            rise_running = 1'b0;
         end
         elapsed = p.now_ms - rise_since;
         if (rise_running && elapsed >= NOW_W'(cfg_rise_hold))
            moving_now = 1'b1;
         elapsed = p.now_ms - fall_since;
         if (fall_running && elapsed >= NOW_W'(cfg_fall_hold))
            moving_now = 1'b0;
      end
      r.moving      = moving_now;
      r.have_sample = got_sample;
      r.held_x      = last_x;
      r.held_y      = last_y;
      r.held_z      = last_z;
      return r;
   endfunction

   function automatic string status_text(rsp_payload_type s);
      return $sformatf("moving=%0b have_sample=%0b held=(%0d,%0d,%0d)",
                       s.moving, s.have_sample, s.held_x, s.held_y, s.held_z);
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s", $time, what);
   endtask

   // Driver: advance to the next poll once the current one has transferred
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_done) begin
         if (poll_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= poll_q.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: predict on each poll transfer, check each result transfer
   always @(posedge clock) begin
      rsp_payload_type want;
      string           bad_fields;
      if (reset) begin
         req_done = 1'b0;
      end else begin
         req_done = req_valid && req_ready;
         if (req_done)
            expected_status_q.push_back(motion_after_poll(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (expected_status_q.size() == 0) begin
               report_mismatch({"result with no poll pending: ", status_text(rsp_payload)});
            end else begin
               want       = expected_status_q.pop_front();
               bad_fields = "";
               if (rsp_payload.moving !== want.moving)
                  bad_fields = {bad_fields, " moving"};
               if (rsp_payload.have_sample !== want.have_sample)
                  bad_fields = {bad_fields, " have_sample"};
               if (rsp_payload.held_x !== want.held_x)
                  bad_fields = {bad_fields, " held_x"};
               if (rsp_payload.held_y !== want.held_y)
                  bad_fields = {bad_fields, " held_y"};
               if (rsp_payload.held_z !== want.held_z)
                  bad_fields = {bad_fields, " held_z"};
               if (bad_fields != "")
                  report_mismatch($sformatf("wrong%s: expected %s, got %s", bad_fields,
                                            status_text(want), status_text(rsp_payload)));
            end
         end
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_HIGH_THRESHOLD_SQ: cfg_high_sq   = data;
         CSR_LOW_THRESHOLD_SQ:  cfg_low_sq    = data;
         CSR_ABOVE_HOLD_MS:     cfg_rise_hold = data[HOLD_W-1:0];
         CSR_BELOW_HOLD_MS:     cfg_fall_hold = data[HOLD_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_poll(input logic kind, input logic signed [15:0] x,
                             input logic signed [15:0] y, input logic signed [15:0] z,
                             input logic [31:0] now);
      req_payload_type p;
      p.kind    = kind;
      p.accel_x = x;
      p.accel_y = y;
      p.accel_z = z;
      p.now_ms  = now;
      poll_q.push_back(p);
   endtask

   // Hold off new polls until every result is back, then let the pipeline settle
   task automatic drain();
      while (poll_q.size() != 0 || req_valid || expected_status_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mostly steady time and magnitude runs so timers can expire; some noise
   task automatic queue_random_run(input int count);
      req_payload_type p;
      int              bound;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 15)
            amp_bits = $urandom_range(2, 15);
         if ($urandom_range(99) < 8) begin
            p.kind    = 1'($urandom_range(1));
            p.accel_x = 16'($urandom);
            p.accel_y = 16'($urandom);
            p.accel_z = 16'($urandom);
            clock_ms  = $urandom;
         end else begin
            bound     = 1 << amp_bits;
            p.kind    = ($urandom_range(99) < 60) ? KIND_SAMPLE : KIND_POLL;
            p.accel_x = 16'(int'($urandom_range(2 * bound - 1)) - bound);
            p.accel_y = 16'(int'($urandom_range(2 * bound - 1)) - bound);
            p.accel_z = 16'(int'($urandom_range(2 * bound - 1)) - bound);
            clock_ms  = clock_ms + $urandom_range(step_max);
         end
         p.now_ms = clock_ms;
         poll_q.push_back(p);
      end
   endtask

   function automatic logic [15:0] pick_hold();
      int r;
      r = $urandom_range(99);
      if (r < 10)
         return 16'd0;
      else if (r < 20)
         return 16'hFFFF;
      return 16'($urandom_range(1, 3000));
   endfunction

   initial begin
      logic [31:0] hi_sq;
      logic [31:0] lo_sq;
      logic [15:0] up_hold;
      logic [15:0] down_hold;
      int          hb;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 28;
      recv_idle_pct = 74;
      // Default thresholds and holds from reset
      queue_poll(KIND_POLL,   0, 0, 0, 32'd0);
      queue_poll(KIND_POLL,   -1, -1, -1, 32'd5);
      queue_poll(KIND_SAMPLE, -32768, -32768, -32768, 32'd0);
      queue_poll(KIND_POLL,   0, 0, 0, 32'd999);
      queue_poll(KIND_POLL,   0, 0, 0, 32'd1000);
      queue_poll(KIND_SAMPLE, 32767, 0, 0, 32'd1001);
      queue_poll(KIND_SAMPLE, 0, 0, 0, 32'hFFFF_FC00);
      queue_poll(KIND_POLL,   0, 0, 0, 32'hFFFF_FFFF);
      queue_poll(KIND_POLL,   0, 0, 0, 32'd1975);
      queue_poll(KIND_SAMPLE, 300, 0, 0, 32'd1976);
      queue_poll(KIND_SAMPLE, -500, 0, 0, 32'd2100);
      queue_poll(KIND_SAMPLE, 0, 300, 0, 32'd3099);
      queue_poll(KIND_POLL,   0, 0, 0, 32'd3100);
      queue_poll(KIND_SAMPLE, 16'h5555, 16'hAAAA, 16'h00FF, 32'hAAAA_5555);
      queue_poll(KIND_SAMPLE, 16'hAAAA, 16'h5555, 16'hFF00, 32'h5555_AAAA);
      queue_poll(KIND_SAMPLE, 32767, 32767, 32767, 32'hFFFF_FFFF);
      queue_poll(KIND_SAMPLE, -32768, 0, 0, 32'd0);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               hi_sq     = 32'd167772;
               lo_sq     = 32'd41943;
               up_hold   = 16'd0;
               down_hold = 16'd0;
               clock_ms  = 32'hFFFF_FF00;
            end
            1: begin
               hi_sq     = 32'd3221225472;
               lo_sq     = 32'd0;
               up_hold   = 16'hFFFF;
               down_hold = 16'hFFFF;
               clock_ms  = $urandom;
            end
            2: begin
               // crossed thresholds
               hi_sq     = 32'd0;
               lo_sq     = 32'd3221225472;
               up_hold   = 16'd5;
               down_hold = 16'd7;
               clock_ms  = $urandom;
            end
            default: begin
               hb    = $urandom_range(4, 15);
               hi_sq = $urandom_range(1 << (2 * hb - 2), 1 << (2 * hb));
               if ($urandom_range(99) < 15)
                  lo_sq = hi_sq + $urandom_range(1 << 20);
               else
                  lo_sq = hi_sq >> $urandom_range(4);
               up_hold   = pick_hold();
               down_hold = pick_hold();
               clock_ms  = $urandom;
            end
         endcase
         step_max = ((up_hold > down_hold) ? up_hold : down_hold) / 6 + 1;
         if (ph < 4) begin
            send_idle_pct = 28;
            recv_idle_pct = 74;
         end else if (ph < 8) begin
            send_idle_pct = 74;
            recv_idle_pct = 28;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_csr(CSR_HIGH_THRESHOLD_SQ, hi_sq);
         write_csr(CSR_LOW_THRESHOLD_SQ, lo_sq);
         write_csr(CSR_ABOVE_HOLD_MS, 32'(up_hold));
         write_csr(CSR_BELOW_HOLD_MS, 32'(down_hold));
         queue_random_run(RUN_LEN);
         drain();
         queue_random_run(RUN_LEN);
         drain();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_status_q.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
